// File: sv/tsosb_pkg.sv
// ----------------------------------------------------------------------------
// tsosb_pkg
// Types and constants shared by the store buffer front end, back end and top.
// ----------------------------------------------------------------------------
package tsosb_pkg;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 64;
	localparam int SIZE_W = 4;
	localparam int LIMIT_W = 6;

	// input function codes
	localparam logic [1:0] FUNC_STORE = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_FENCE = 2'd2;

	// result kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] access_size;
		logic [DATA_W-1:0] store_value;
		logic [DATA_W-1:0] memory_data;
		logic              ordered;
		logic              direct;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] write_address;
		logic [SIZE_W-1:0] write_size;
		logic [DATA_W-1:0] data;
		logic              last;
	} rsp_t;

	// decoded operation handed from front to back
	typedef enum logic [2:0] {
		OP_STORE,
		OP_STORE_ORD,
		OP_STORE_DIR,
		OP_LOAD,
		OP_LOAD_DIR,
		OP_FENCE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] size;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] mem;
		logic [7:0]        need;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN_RD,
		ST_DRAIN_WR,
		ST_APPEND,
		ST_SELF,
		ST_LOAD_RD,
		ST_LOAD_CHK,
		ST_LOAD_OUT
	} state_t;

	// byte enable mask for a size of 1..8 bytes
	function automatic logic [7:0] byte_need(input logic [SIZE_W-1:0] s);
		logic [7:0] m;
		m = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (SIZE_W'(i) < s) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic logic [DATA_W-1:0] expand_mask(input logic [7:0] m);
		logic [DATA_W-1:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = {8{m[i]}};
		end
		return r;
	endfunction

endpackage

// File: sv/tsosb_ram.sv
// ----------------------------------------------------------------------------
// tsosb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsosb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// File: sv/tsosb_front.sv
// ----------------------------------------------------------------------------
// tsosb_front
// Accepts request beats, normalizes size and data, classifies the operation
// and queues it for the back end in a two-entry command queue.
// ----------------------------------------------------------------------------
module tsosb_front
	import tsosb_pkg::*;
#(
	parameter int ADDRESS_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;

	logic [SIZE_W-1:0] size_n;
	logic [7:0]        need;
	logic [DATA_W-1:0] mask;
	logic              keep;
	cmd_t              dec;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	// decode and classify
	always_comb begin
		if (req.access_size == '0) begin
			size_n = SIZE_W'(1);
		end else if (req.access_size > SIZE_W'(8)) begin
			size_n = SIZE_W'(8);
		end else begin
			size_n = req.access_size;
		end
		need = byte_need(size_n);
		mask = expand_mask(need);
		keep = 1'b1;
		dec.op = OP_STORE;
		unique case (req.func)
			FUNC_STORE: begin
				if (req.direct) begin
					dec.op = OP_STORE_DIR;
				end else if (req.ordered) begin
					dec.op = OP_STORE_ORD;
				end else begin
					dec.op = OP_STORE;
				end
			end
			FUNC_LOAD: begin
				dec.op = req.direct ? OP_LOAD_DIR : OP_LOAD;
			end
			FUNC_FENCE: begin
				dec.op = OP_FENCE;
				keep = req.ordered && !req.direct;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		dec.address = ADDR_W'(req.address[AW-1:0]);
		dec.size = size_n;
		dec.value = req.store_value & mask;
		dec.mem = req.memory_data & mask;
		dec.need = need;
	end

	// command queue
	assign full = (cnt_q == 2'd2);
	assign wr_en = push && !full && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign rd_en = cmd_valid && cmd_ready;
	assign cmd = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// File: sv/tsosb_back.sv
// ----------------------------------------------------------------------------
// tsosb_back
// Executes queued commands against the circular store buffer: drains,
// appends, load forwarding scan, and a two-entry result queue.
// ----------------------------------------------------------------------------
module tsosb_back
	import tsosb_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32,
	parameter int ADDRESS_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  cmd_t               cmd,
	input  logic [LIMIT_W-1:0] limit,
	output logic               empty,
	input  logic               pop,
	output rsp_t               rsp
);

	localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int EW = AW + SIZE_W + DATA_W;

	state_t state_q, state_d;
	cmd_t   cur_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] scan_q;
	logic [DATA_W-1:0] result_q;
	logic [7:0]        filled_q;

	logic [CW-1:0] lim_eff;
	logic [IW-1:0] tail_idx;
	logic [IW-1:0] scan_idx;
	logic [IW-1:0] head_inc;
	logic [CW:0]   sum_t;
	logic [CW:0]   sum_s;

	logic          ram_we;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	logic [AW-1:0]     e_addr;
	logic [SIZE_W-1:0] e_size;
	logic [DATA_W-1:0] e_value;
	logic [DATA_W-1:0] merge_res;
	logic [7:0]        merge_fill;

	logic       out_push;
	rsp_t       out_item;
	rsp_t       oslot_q [2];
	logic       owp_q;
	logic       orp_q;
	logic [1:0] ocnt_q;
	logic       out_space;
	logic       out_pop;

	// effective limit and ring index arithmetic
	always_comb begin
		if (limit == '0 || {1'b0, limit} > 7'(BUFFER_DEPTH)) begin
			lim_eff = CW'(BUFFER_DEPTH);
		end else begin
			lim_eff = CW'(limit);
		end
		sum_t = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (sum_t >= (CW+1)'(BUFFER_DEPTH)) begin
			sum_t = sum_t - (CW+1)'(BUFFER_DEPTH);
		end
		tail_idx = sum_t[IW-1:0];
		sum_s = (CW+1)'(head_q) + (CW+1)'(scan_q);
		if (sum_s >= (CW+1)'(BUFFER_DEPTH)) begin
			sum_s = sum_s - (CW+1)'(BUFFER_DEPTH);
		end
		scan_idx = sum_s[IW-1:0];
		if ((CW+1)'(head_q) == (CW+1)'(BUFFER_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + IW'(1);
		end
	end

	assign ram_wdata = {cur_q.address[AW-1:0], cur_q.size, cur_q.value};
	assign {e_addr, e_size, e_value} = ram_rdata;

	tsosb_ram #(
		.WIDTH(EW),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (tail_idx),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	// byte merge of one buffered entry into the load result
	always_comb begin
		logic [ADDRESS_BITS-1:0] ba;
		logic [ADDRESS_BITS-1:0] off;
		merge_res = result_q;
		merge_fill = filled_q;
		for (int i = 0; i < 8; i++) begin
			ba = ADDRESS_BITS'(cur_q.address[AW-1:0]) + ADDRESS_BITS'(i);
			off = ba - ADDRESS_BITS'(e_addr);
			if (!filled_q[i] && off < ADDRESS_BITS'(e_size)) begin
				merge_res[8*i +: 8] = e_value[8*off[2:0] +: 8];
				merge_fill[i] = 1'b1;
			end
		end
	end

	// next state and datapath controls
	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_raddr = head_q;
		out_push = 1'b0;
		out_item.kind = KIND_WRITE;
		out_item.write_address = ADDR_W'(e_addr);
		out_item.write_size = e_size;
		out_item.data = e_value;
		out_item.last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_STORE_DIR: state_d = ST_SELF;
						OP_STORE_ORD: state_d = (count_q != '0) ? ST_DRAIN_RD : ST_SELF;
						OP_FENCE: state_d = (count_q != '0) ? ST_DRAIN_RD : ST_IDLE;
						OP_STORE: begin
							if (count_q >= lim_eff && count_q != '0) begin
								state_d = ST_DRAIN_RD;
							end else begin
								state_d = ST_APPEND;
							end
						end
						OP_LOAD_DIR: state_d = ST_LOAD_OUT;
						OP_LOAD: state_d = (count_q != '0) ? ST_LOAD_RD : ST_LOAD_OUT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAIN_RD: begin
				ram_re = 1'b1;
				ram_raddr = head_q;
				state_d = ST_DRAIN_WR;
			end
			ST_DRAIN_WR: begin
				out_item.last = (rem_q == CW'(1)) && (cur_q.op != OP_STORE_ORD);
				if (out_space) begin
					out_push = 1'b1;
					if (rem_q != CW'(1)) begin
						state_d = ST_DRAIN_RD;
					end else if (cur_q.op == OP_STORE) begin
						state_d = ST_APPEND;
					end else if (cur_q.op == OP_STORE_ORD) begin
						state_d = ST_SELF;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_APPEND: begin
				ram_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SELF: begin
				out_item.write_address = cur_q.address;
				out_item.write_size = cur_q.size;
				out_item.data = cur_q.value;
				out_item.last = 1'b1;
				if (out_space) begin
					out_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LOAD_RD: begin
				ram_re = 1'b1;
				ram_raddr = scan_idx;
				state_d = ST_LOAD_CHK;
			end
			ST_LOAD_CHK: begin
				if (scan_q == '0 || (&merge_fill)) begin
					state_d = ST_LOAD_OUT;
				end else begin
					state_d = ST_LOAD_RD;
				end
			end
			ST_LOAD_OUT: begin
				out_item.kind = KIND_LOAD;
				out_item.write_address = '0;
				out_item.write_size = '0;
				out_item.data = result_q;
				out_item.last = 1'b1;
				if (out_space) begin
					out_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and buffer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			rem_q <= '0;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					rem_q <= (cmd.op == OP_STORE) ? CW'(1) : count_q;
					scan_q <= count_q - CW'(1);
				end
				ST_DRAIN_WR: begin
					if (out_space) begin
						head_q <= head_inc;
						count_q <= count_q - CW'(1);
						rem_q <= rem_q - CW'(1);
					end
				end
				ST_APPEND: count_q <= count_q + CW'(1);
				ST_LOAD_CHK: scan_q <= scan_q - CW'(1);
				default: begin
				end
			endcase
		end
	end

	// command and load payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cur_q <= cmd;
			result_q <= cmd.mem;
			filled_q <= ~cmd.need;
		end else if (state_q == ST_LOAD_CHK) begin
			result_q <= merge_res;
			filled_q <= merge_fill;
		end
	end

	// result queue
	assign out_space = (ocnt_q != 2'd2);
	assign empty = (ocnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign rsp = oslot_q[orp_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			oslot_q[owp_q] <= out_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (out_push) begin
				owp_q <= !owp_q;
			end
			if (out_pop) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

endmodule

// File: sv/tso_store_buffer_forwarding_core.sv
// ----------------------------------------------------------------------------
// tso_store_buffer_forwarding_core
// FIFO store buffer with store-to-load forwarding, TSO ordering.
// ----------------------------------------------------------------------------
// Requests enter through push/full; a beat is taken when push is high and
// full is low. Results leave through empty/pop; the oldest result sits on rsp
// while empty is low and is taken when pop is high. Each request yields zero
// or more results; the final one of a request carries last.
// Processing: a request crosses the command queue and is decoded; each buffered
// entry drained passes ST_DRAIN_RD and ST_DRAIN_WR, and each entry scanned by
// a load passes ST_LOAD_RD and ST_LOAD_CHK (newest first, stopping once every
// byte is found), since the entry RAM has one registered read port. A direct
// access or a plain store without a drain needs no read of the entry RAM.
// A two-entry command queue and a two-entry result queue decouple the sides;
// if pop stays low, the back end stops after two results and the front keeps
// taking requests until its queue fills.
// Reset empties both queues and the buffer and sets the limit to 32; no
// clearing pass is needed. The limit is written on cfg_valid/cfg_ready, and
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module tso_store_buffer_forwarding_core
	import tsosb_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32,
	parameter int ADDRESS_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  req_t               req,
	output logic               empty,
	input  logic               pop,
	output rsp_t               rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0] limit_q;
	logic               cmd_valid;
	logic               cmd_ready;
	cmd_t               cmd;

	// limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(32);
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	tsosb_front #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	tsosb_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.limit    (limit_q),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

// File: verif/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker
// Watches the request, result and limit channels of the store buffer, keeps
// a shadow copy of the buffered stores, predicts every result beat and
// compares each popped beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_checker
	import tsosb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  req_t               req,
	input  logic               empty,
	input  logic               pop,
	input  rsp_t               rsp,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data,
	output int                 errors,
	output int                 pending
);

	localparam int DEPTH = 32;

	// shadow store buffer, oldest entry at index 0
	logic [ADDR_W-1:0]  sb_addr [DEPTH];
	logic [DATA_W-1:0]  sb_val  [DEPTH];
	logic [SIZE_W-1:0]  sb_size [DEPTH];
	int                 sb_count;
	logic [LIMIT_W-1:0] sb_limit;

	rsp_t expected_rsp[$];
	rsp_t batch[$];

	initial begin
		errors = 0;
		pending = 0;
		sb_count = 0;
		sb_limit = 6'd32;
	end

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("tb_checker: %0s mismatch, got %h want %h", field, got, want);
		errors++;
	endtask

	function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] s);
		if (s >= 8) begin
			return '1;
		end
		return (64'd1 << (8 * s)) - 64'd1;
	endfunction

	task automatic add_write(input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] s,
			input logic [DATA_W-1:0] d);
		rsp_t r;
		r.kind = KIND_WRITE;
		r.write_address = a;
		r.write_size = s;
		r.data = d;
		r.last = 1'b0;
		batch = {batch, r};
	endtask

	task automatic drain_all();
		for (int i = 0; i < sb_count; i++) begin
			add_write(sb_addr[i], sb_size[i], sb_val[i]);
		end
		sb_count = 0;
	endtask

	// predict the result beats of one request and update the shadow buffer
	task automatic predict_req(input req_t r);
		logic [SIZE_W-1:0] sz;
		logic [DATA_W-1:0] sval;
		logic [DATA_W-1:0] ld;
		logic [ADDR_W-1:0] ba;
		logic [ADDR_W-1:0] off;
		logic [7:0]        b;
		int                lim;
		rsp_t              lr;
		sz = r.access_size;
		if (sz == 4'd0) sz = 4'd1;
		if (sz > 4'd8) sz = 4'd8;
		sval = r.store_value & size_mask(sz);
		lim = (sb_limit == 0 || sb_limit > DEPTH) ? DEPTH : sb_limit;
		batch.delete();
		case (r.func)
			FUNC_STORE: begin
				if (r.direct) begin
					add_write(r.address, sz, sval);
				end else if (r.ordered) begin
					drain_all();
					add_write(r.address, sz, sval);
				end else begin
					// over the limit: drain just the oldest entry
					if (sb_count >= lim && sb_count > 0) begin
						add_write(sb_addr[0], sb_size[0], sb_val[0]);
						for (int i = 0; i < DEPTH - 1; i++) begin
							sb_addr[i] = sb_addr[i+1];
							sb_val[i] = sb_val[i+1];
							sb_size[i] = sb_size[i+1];
						end
						sb_count--;
					end
					if (sb_count < DEPTH) begin
						sb_addr[sb_count] = r.address;
						sb_val[sb_count] = sval;
						sb_size[sb_count] = sz;
						sb_count++;
					end
				end
			end
			FUNC_LOAD: begin
				ld = '0;
				if (r.direct) begin
					ld = r.memory_data & size_mask(sz);
				end else begin
					// byte merge, newest entry wins, addresses wrap
					for (int i = 0; i < sz; i++) begin
						ba = r.address + ADDR_W'(i);
						b = r.memory_data[8*i +: 8];
						for (int k = sb_count - 1; k >= 0; k--) begin
							off = ba - sb_addr[k];
							if (off < ADDR_W'(sb_size[k])) begin
								b = sb_val[k][8*off[2:0] +: 8];
								break;
							end
						end
						ld[8*i +: 8] = b;
					end
				end
				lr.kind = KIND_LOAD;
				lr.write_address = '0;
				lr.write_size = '0;
				lr.data = ld;
				lr.last = 1'b0;
				batch = {batch, lr};
			end
			FUNC_FENCE: begin
				if (!r.direct && r.ordered) begin
					drain_all();
				end
			end
			default: begin
			end
		endcase
		if (batch.size() > 0) begin
			batch[batch.size()-1].last = 1'b1;
		end
		foreach (batch[i]) begin
			expected_rsp = {expected_rsp, batch[i]};
		end
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			report("unexpected beat", got.data, 64'd0);
			return;
		end
		want = expected_rsp.pop_front();
		if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
		if (got.write_address !== want.write_address)
			report("write_address", 64'(got.write_address), 64'(want.write_address));
		if (got.write_size !== want.write_size)
			report("write_size", 64'(got.write_size), 64'(want.write_size));
		if (got.data !== want.data) report("data", got.data, want.data);
		if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
	endtask

	// sample all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_count = 0;
			sb_limit = 6'd32;
			expected_rsp.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				sb_limit = cfg_data;
			end
			if (pop && !empty) begin
				check_rsp(rsp);
			end
			if (push && !full) begin
				predict_req(req);
			end
		end
		pending = expected_rsp.size();
	end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the store buffer: directed corner cases, then
// random phases under several drain limits with bursty pushes and random pop
// stalls. Checking is done by tb_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import tsosb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 150;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	req_t               req;
	logic               empty;
	logic               pop;
	rsp_t               rsp;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;
	int                 errors;
	int                 pending;
	int                 idle_cycles;
	int                 burst_left;
	int                 pop_mode;
	int                 pop_mode_left;

	tso_store_buffer_forwarding_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tb_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always #10 clk = ~clk;

	// pop pattern: free-running, random, or mostly stalled stretches
	always @(posedge clk) begin
		if (pop_mode_left == 0) begin
			pop_mode <= $urandom_range(0, 2);
			pop_mode_left <= $urandom_range(20, 80);
		end else begin
			pop_mode_left <= pop_mode_left - 1;
		end
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			default: pop <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [1:0] f, input logic [31:0] a,
			input logic [3:0] s, input logic ord, input logic dir);
		req_t r;
		r.func = f;
		r.address = a;
		r.access_size = s;
		r.store_value = {$urandom, $urandom};
		r.memory_data = {$urandom, $urandom};
		r.ordered = ord;
		r.direct = dir;
		return r;
	endfunction

	// random request around a base window, store share in percent
	function automatic req_t rand_req(input logic [31:0] base, input int store_pct);
		logic [1:0]  f;
		logic [31:0] a;
		logic [3:0]  s;
		int          p;
		p = $urandom_range(0, 99);
		if (p < store_pct) f = FUNC_STORE;
		else if (p < 88) f = FUNC_LOAD;
		else if (p < 97) f = FUNC_FENCE;
		else f = 2'd3;
		a = ($urandom_range(0, 19) == 0) ? $urandom : base + $urandom_range(0, 23);
		if ($urandom_range(0, 6) == 0) s = 4'($urandom_range(0, 15));
		else s = 4'd1 << $urandom_range(0, 3);
		return make_req(f, a, s,
			(f == FUNC_FENCE) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0),
			$urandom_range(0, 11) == 0);
	endfunction

	// one request beat, followed by a random gap at the end of a burst
	task automatic send_req(input req_t r);
		int gap;
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int n, input logic [31:0] base, input int store_pct);
		for (int i = 0; i < n; i++) begin
			send_req(rand_req(base, store_pct));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		req = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		burst_left = 0;
		pop_mode = 0;
		pop_mode_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sizes, overlap, wrap, bypass, ordering, odd codes
		send_req(make_req(FUNC_FENCE, 32'h0, 4'd8, 1'b1, 1'b0));     // fence, empty buffer
		send_req(make_req(FUNC_STORE, 32'h100, 4'd8, 1'b0, 1'b0));
		send_req(make_req(FUNC_STORE, 32'h102, 4'd2, 1'b0, 1'b0));
		send_req(make_req(FUNC_STORE, 32'h104, 4'd1, 1'b0, 1'b0));
		send_req(make_req(FUNC_STORE, 32'h105, 4'd0, 1'b0, 1'b0));   // size zero
		send_req(make_req(FUNC_STORE, 32'h106, 4'd15, 1'b0, 1'b0));  // oversize
		send_req(make_req(FUNC_STORE, 32'h109, 4'd3, 1'b0, 1'b0));   // odd size
		send_req(make_req(FUNC_LOAD, 32'h100, 4'd8, 1'b0, 1'b0));
		send_req(make_req(FUNC_LOAD, 32'h103, 4'd4, 1'b0, 1'b0));
		send_req(make_req(FUNC_LOAD, 32'h0FE, 4'd8, 1'b0, 1'b0));    // partly from memory
		send_req(make_req(FUNC_LOAD, 32'h100, 4'd8, 1'b1, 1'b1));    // direct load
		send_req(make_req(FUNC_STORE, 32'h200, 4'd4, 1'b1, 1'b1));   // direct store
		send_req(make_req(FUNC_FENCE, 32'h0, 4'd1, 1'b0, 1'b0));     // plain fence
		send_req(make_req(FUNC_FENCE, 32'h0, 4'd1, 1'b1, 1'b1));     // direct fence
		send_req(make_req(2'd3, 32'hFFFFFFFF, 4'd15, 1'b1, 1'b1));   // unused code
		send_req(make_req(FUNC_STORE, 32'hFFFFFFFF, 4'd4, 1'b0, 1'b0)); // wraps
		send_req(make_req(FUNC_LOAD, 32'hFFFFFFFE, 4'd4, 1'b0, 1'b0));
		send_req(make_req(FUNC_LOAD, 32'h00000001, 4'd2, 1'b1, 1'b0));
		send_req(make_req(FUNC_STORE, 32'h300, 4'd8, 1'b1, 1'b0));   // ordered store
		send_req(make_req(FUNC_STORE, 32'h100, 4'd8, 1'b0, 1'b0));
		send_req(make_req(FUNC_STORE, 32'h100, 4'd4, 1'b0, 1'b0));
		send_req(make_req(FUNC_LOAD, 32'h100, 4'd2, 1'b0, 1'b0));
		send_req(make_req(FUNC_FENCE, 32'h0, 4'd2, 1'b1, 1'b0));     // ordered fence
		run_phase(20, 32'h100, 60);
		wait_idle();

		// random phases under different drain limits
		write_limit(6'd1);
		run_phase(30, 32'h400, 55);
		wait_idle();
		write_limit(6'd3);
		run_phase(30, 32'hFFFFFFF4, 55);
		wait_idle();
		write_limit(6'd0);
		run_phase(30, $urandom, 50);
		wait_idle();
		write_limit(6'd63);
		run_phase(30, 32'h800, 65);
		wait_idle();
		write_limit(6'd40);
		run_phase(30, 32'h1000, 50);
		wait_idle();
		// fill deep, then lower the limit under a full buffer
		write_limit(6'd32);
		run_phase(40, 32'h2000, 80);
		wait_idle();
		write_limit(6'd2);
		run_phase(35, 32'h2000, 60);
		wait_idle();

		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// File: files.f
sv/tsosb_pkg.sv
sv/tsosb_ram.sv
sv/tsosb_front.sv
sv/tsosb_back.sv
sv/tso_store_buffer_forwarding_core.sv
verif/tb_checker.sv
verif/tb_top.sv
